// ----- design/assert_macros.svh -----
// assertion helpers used by the queue module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define LPI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property whose consequent must hold in the cycle after its antecedent
`define LPI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/lpi_pkg.sv -----
package lpi_pkg;

	// coordinate format and derived widths
	localparam int CW         = 32;
	localparam int UW         = CW + 1;
	localparam int PW         = 2 * CW + 1;
	localparam int DW         = PW + 2;
	localparam int QB         = CW + 2;
	localparam int NLO        = CW + 2;
	localparam int NHI        = DW - NLO;
	localparam int MW         = UW + DW;
	localparam int PLW        = UW + NLO + 1;
	localparam int PHW        = UW + NHI;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef logic [2:0][CW-1:0] vec_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic [2:0][CW-1:0] s;
		logic [2:0][UW-1:0] u;
		logic [DW-1:0]      num;
		logic [DW-1:0]      den;
		logic               par;
	} job_t;

endpackage

// ----- design/lpi_front.sv -----
module lpi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lpi_pkg::vec_t start,
	input  lpi_pkg::vec_t stop,
	input  lpi_pkg::vec_t plane,
	input  lpi_pkg::vec_t normal,
	input  logic          pop,
	output logic          push,
	output lpi_pkg::job_t job
);
	import lpi_pkg::*;

	logic                 acc;
	logic [CNT_W-1:0]     used_q;
	logic                 v_s1, v_s2, v_s3;
	logic signed [CW-1:0] s_s1 [3];
	logic signed [CW-1:0] s_s2 [3];
	logic signed [CW-1:0] s_s3 [3];
	logic signed [UW-1:0] u_s1 [3];
	logic signed [UW-1:0] u_s2 [3];
	logic signed [UW-1:0] u_s3 [3];
	logic signed [UW-1:0] w_s1 [3];
	logic signed [CW-1:0] n_s1 [3];
	logic signed [PW-1:0] nu_s2 [3];
	logic signed [PW-1:0] nw_s2 [3];
	logic signed [DW-1:0] num_c, den_c;
	logic signed [DW-1:0] num_s3, den_s3;
	logic                 par_s3;

	// credits cover words in flight and words in the queue
	assign acc      = in_valid && !in_stall;
	assign in_stall = (used_q == CNT_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (acc && !pop) begin
			used_q <= used_q + CNT_W'(1);
		end else if (!acc && pop) begin
			used_q <= used_q - CNT_W'(1);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// direction and offset vectors, then the six products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			s_s1[k]  <= $signed(start[k]);
			u_s1[k]  <= $signed({stop[k][CW-1], stop[k]}) - $signed({start[k][CW-1], start[k]});
			w_s1[k]  <= $signed({plane[k][CW-1], plane[k]}) - $signed({start[k][CW-1], start[k]});
			n_s1[k]  <= $signed(normal[k]);
			s_s2[k]  <= s_s1[k];
			u_s2[k]  <= u_s1[k];
			nu_s2[k] <= n_s1[k] * u_s1[k];
			nw_s2[k] <= n_s1[k] * w_s1[k];
			s_s3[k]  <= s_s2[k];
			u_s3[k]  <= u_s2[k];
		end
	end

	// dot products and parallel test
	always_comb begin
		num_c = DW'(nw_s2[0]) + DW'(nw_s2[1]) + DW'(nw_s2[2]);
		den_c = DW'(nu_s2[0]) + DW'(nu_s2[1]) + DW'(nu_s2[2]);
	end

	always_ff @(posedge clk) begin
		num_s3 <= num_c;
		den_s3 <= den_c;
		par_s3 <= (den_c == '0);
	end

	// word to the queue
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			job.s[k] = s_s3[k];
			job.u[k] = u_s3[k];
		end
		job.num = num_s3;
		job.den = den_s3;
		job.par = par_s3;
	end

	assign push = v_s3;

endmodule

// ----- design/lpi_fifo.sv -----
`include "assert_macros.svh"

module lpi_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpi_pkg::job_t din,
	input  logic          pop,
	output lpi_pkg::job_t dout,
	output logic          nonempty
);
	import lpi_pkg::*;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign dout     = mem_q[rd_q];
	assign nonempty = (count_q != '0);

	`LPI_ASSERT(a_no_overrun, !(push && !pop && count_q == CNT_W'(FIFO_DEPTH)), "queue overrun")
	`LPI_ASSERT(a_no_underrun, !(pop && count_q == '0), "queue underrun")
	`LPI_ASSERT_NEXT(a_fill_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "fill count")

endmodule

// ----- design/lpi_back.sv -----
module lpi_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lpi_pkg::job_t job,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output lpi_pkg::vec_t hit,
	output logic          par_out,
	output logic          ovf_out
);
	import lpi_pkg::*;

	localparam logic signed [QB+1:0] HI = {{(QB+3-CW){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [QB+1:0] LO = {{(QB+3-CW){1'b1}}, {(CW-1){1'b0}}};

	logic en;
	logic v_s1, v_s2, v_s3, v_s5, out_valid_q;

	logic signed [PLW-1:0] pl_s1 [3];
	logic signed [PHW-1:0] ph_s1 [3];
	logic signed [CW-1:0]  s_s1 [3];
	logic signed [CW-1:0]  s_s2 [3];
	logic signed [CW-1:0]  s_s3 [3];
	logic signed [DW-1:0]  den_s1, den_s2;
	logic                  par_s1, par_s2, par_s3, par_s5;
	logic signed [MW-1:0]  prod_c [3];
	logic signed [MW-1:0]  prod_s2 [3];
	logic [MW-1:0]         mag_s3 [3];
	logic                  neg_s3 [3];
	logic [DW-1:0]         dmag_s3;

	// divider pipeline, entry zero is the setup stage
	logic                  v_sd [QB+1];
	logic                  par_sd [QB+1];
	logic [DW-1:0]         d_sd [QB];
	logic [DW-1:0]         rem_sd [QB][3];
	logic [QB-1:0]         lb_sd [QB][3];
	logic [QB-1:0]         q_sd [QB+1][3];
	logic                  neg_sd [QB+1][3];
	logic                  big_sd [QB+1][3];
	logic signed [CW-1:0]  s_sd [QB+1][3];
	logic [DW-1:0]         nrem [QB][3];
	logic [QB-1:0]         nq [QB][3];

	logic signed [QB:0]    qs_s5 [3];
	logic                  big_s5 [3];
	logic                  neg_s5 [3];
	logic signed [CW-1:0]  s_s5 [3];

	logic signed [QB+1:0]  h_c [3];
	logic [CW-1:0]         hit_c [3];
	logic [2:0]            sat_c;
	logic [CW-1:0]         hit_q [3];
	logic                  par_q, ovf_q;

	// whole pipeline holds while a result waits
	assign en  = !(out_valid_q && out_stall);
	assign pop = en && head_valid;

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				v_sd[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_sd[0] <= v_s3;
			for (int j = 1; j <= QB; j++) begin
				v_sd[j] <= v_sd[j-1];
			end
			v_s5        <= v_sd[QB];
			out_valid_q <= v_s5;
		end
	end

	// partial products of u times the numerator, summed next stage
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = (MW'(ph_s1[k]) <<< NLO) + MW'(pl_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pl_s1[k] <= $signed(job.u[k]) * $signed({1'b0, job.num[NLO-1:0]});
				ph_s1[k] <= $signed(job.u[k]) * $signed(job.num[DW-1:NLO]);
				s_s1[k]  <= $signed(job.s[k]);
				prod_s2[k] <= prod_c[k];
				s_s2[k]  <= s_s1[k];
				mag_s3[k] <= prod_s2[k][MW-1] ? MW'(-prod_s2[k]) : MW'(prod_s2[k]);
				neg_s3[k] <= prod_s2[k][MW-1] ^ den_s2[DW-1];
				s_s3[k]  <= s_s2[k];
			end
			den_s1  <= $signed(job.den);
			par_s1  <= job.par;
			den_s2  <= den_s1;
			par_s2  <= par_s1;
			dmag_s3 <= den_s2[DW-1] ? DW'(-den_s2) : DW'(den_s2);
			par_s3  <= par_s2;
		end
	end

	// one quotient bit per divider stage
	always_comb begin
		logic [DW:0] r2;
		logic [DW:0] df;
		for (int j = 0; j < QB; j++) begin
			for (int k = 0; k < 3; k++) begin
				r2 = {rem_sd[j][k], lb_sd[j][k][QB-1]};
				df = {1'b0, d_sd[j]};
				if (r2 >= df) begin
					nrem[j][k] = DW'(r2 - df);
					nq[j][k]   = {q_sd[j][k][QB-2:0], 1'b1};
				end else begin
					nrem[j][k] = DW'(r2);
					nq[j][k]   = {q_sd[j][k][QB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// setup: high part seeds the remainder, oversize quotient saturates
			d_sd[0]   <= dmag_s3;
			par_sd[0] <= par_s3;
			for (int k = 0; k < 3; k++) begin
				rem_sd[0][k] <= DW'(mag_s3[k][MW-1:QB]);
				lb_sd[0][k]  <= mag_s3[k][QB-1:0];
				q_sd[0][k]   <= '0;
				big_sd[0][k] <= (DW'(mag_s3[k][MW-1:QB]) >= dmag_s3);
				neg_sd[0][k] <= neg_s3[k];
				s_sd[0][k]   <= s_s3[k];
			end
			// divisor, remainder and dividend bits are needed up to the last stage only
			for (int j = 1; j < QB; j++) begin
				d_sd[j] <= d_sd[j-1];
				for (int k = 0; k < 3; k++) begin
					rem_sd[j][k] <= nrem[j-1][k];
					lb_sd[j][k]  <= {lb_sd[j-1][k][QB-2:0], 1'b0};
				end
			end
			for (int j = 1; j <= QB; j++) begin
				par_sd[j] <= par_sd[j-1];
				for (int k = 0; k < 3; k++) begin
					q_sd[j][k]   <= nq[j-1][k];
					big_sd[j][k] <= big_sd[j-1][k];
					neg_sd[j][k] <= neg_sd[j-1][k];
					s_sd[j][k]   <= s_sd[j-1][k];
				end
			end
			// apply quotient sign
			par_s5 <= par_sd[QB];
			for (int k = 0; k < 3; k++) begin
				qs_s5[k]  <= neg_sd[QB][k] ? -$signed({1'b0, q_sd[QB][k]})
				                           : $signed({1'b0, q_sd[QB][k]});
				big_s5[k] <= big_sd[QB][k];
				neg_s5[k] <= neg_sd[QB][k];
				s_s5[k]   <= s_sd[QB][k];
			end
		end
	end

	// add start point and saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			h_c[k] = (QB+2)'(s_s5[k]) + (QB+2)'(qs_s5[k]);
			if (par_s5) begin
				hit_c[k] = '0;
				sat_c[k] = 1'b0;
			end else if (big_s5[k]) begin
				hit_c[k] = neg_s5[k] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
				sat_c[k] = 1'b1;
			end else if (h_c[k] > HI) begin
				hit_c[k] = {1'b0, {(CW-1){1'b1}}};
				sat_c[k] = 1'b1;
			end else if (h_c[k] < LO) begin
				hit_c[k] = {1'b1, {(CW-1){1'b0}}};
				sat_c[k] = 1'b1;
			end else begin
				hit_c[k] = h_c[k][CW-1:0];
				sat_c[k] = 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				hit_q[k] <= hit_c[k];
			end
			par_q <= par_s5;
			ovf_q <= |sat_c;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hit[k] = hit_q[k];
		end
	end

	assign out_valid = out_valid_q;
	assign par_out   = par_q;
	assign ovf_out   = ovf_q;

endmodule

// ----- design/line_plane_intersect.sv -----
// line and plane intersection in signed fixed point, one word per cycle while neither stall holds
// built from a 3-stage front, the queue, and a 40-stage back with a 34-stage restoring divider
// throughput is one word per cycle while no stall holds it; an 8-entry queue with credits decouples the two parts
// reset: asynchronous, active low; clears valids, credits and queue pointers
module line_plane_intersect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [lpi_pkg::CW-1:0] start_x,
	input  logic signed [lpi_pkg::CW-1:0] start_y,
	input  logic signed [lpi_pkg::CW-1:0] start_z,
	input  logic signed [lpi_pkg::CW-1:0] end_x,
	input  logic signed [lpi_pkg::CW-1:0] end_y,
	input  logic signed [lpi_pkg::CW-1:0] end_z,
	input  logic signed [lpi_pkg::CW-1:0] plane_px,
	input  logic signed [lpi_pkg::CW-1:0] plane_py,
	input  logic signed [lpi_pkg::CW-1:0] plane_pz,
	input  logic signed [lpi_pkg::CW-1:0] normal_x,
	input  logic signed [lpi_pkg::CW-1:0] normal_y,
	input  logic signed [lpi_pkg::CW-1:0] normal_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [lpi_pkg::CW-1:0] hit_x,
	output logic signed [lpi_pkg::CW-1:0] hit_y,
	output logic signed [lpi_pkg::CW-1:0] hit_z,
	output logic                        parallel,
	output logic                        overflow
);
	import lpi_pkg::*;

	vec_t start, stop, plane, normal, hit;
	job_t push_job, head_job;
	logic push, pop, head_valid;

	assign start  = {start_z, start_y, start_x};
	assign stop   = {end_z, end_y, end_x};
	assign plane  = {plane_pz, plane_py, plane_px};
	assign normal = {normal_z, normal_y, normal_x};

	// front: vectors, dot products, classification
	lpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.start    (start),
		.stop     (stop),
		.plane    (plane),
		.normal   (normal),
		.pop      (pop),
		.push     (push),
		.job      (push_job)
	);

	// queue between front and back
	lpi_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (push_job),
		.pop      (pop),
		.dout     (head_job),
		.nonempty (head_valid)
	);

	// back: scaling, division, saturation
	lpi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.par_out    (parallel),
		.ovf_out    (overflow)
	);

	assign hit_x = $signed(hit[0]);
	assign hit_y = $signed(hit[1]);
	assign hit_z = $signed(hit[2]);

endmodule
